// ----- rtl/ddl_pkg.sv -----
// Shared constants and types for the decimating depth logger.
`timescale 1ns / 1ps

package ddl_pkg;

  // Default trace buffer depth
  localparam int SAMPLE_SLOTS_DEF = 256;

  // Field widths fixed by the item layout
  localparam int DEPTH_W    = 16;
  localparam int DTIME_W    = 16;
  localparam int RIDX_W     = 8;
  localparam int INTERVAL_W = 8;
  localparam int SECS_W     = 8;
  localparam int COUNT_W    = 9;

  // Reset and limit values
  localparam logic [7:0]         START_DELAY_RST = 8'd5;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 8'd2;
  localparam logic [INTERVAL_W-1:0] INTERVAL_LIMIT = 8'd127;
  localparam logic [DEPTH_W-1:0] FILL_VALUE      = 16'hFFFF;

  // Logging phase codes
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_STARTED   = 2'd1;
  localparam logic [1:0] PH_CONFIRMED = 2'd3;

  // Item kinds carried in tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Buffer work requested by one tick
  localparam logic [1:0] JOB_NONE     = 2'd0;
  localparam logic [1:0] JOB_STORE    = 2'd1;
  localparam logic [1:0] JOB_COMPRESS = 2'd2;
  localparam logic [1:0] JOB_CLEAR    = 2'd3;

  // Scalar logging state
  typedef struct packed {
    logic [1:0]            phase;
    logic [INTERVAL_W-1:0] interval;
    logic [SECS_W-1:0]     sec_count;
  } scal_t;

endpackage

// ----- rtl/ddl_tick.sv -----
// Next-state decision for one second tick of the depth logger.
`timescale 1ns / 1ps

module ddl_tick #(
  parameter int SAMPLE_SLOTS = ddl_pkg::SAMPLE_SLOTS_DEF,
  parameter int PW           = $clog2(SAMPLE_SLOTS + 1)
) (
  input  logic                       dive_active,
  input  logic [ddl_pkg::DTIME_W-1:0] dive_time_s,
  input  logic [7:0]                 start_delay_s,
  input  ddl_pkg::scal_t             cur,
  input  logic [PW-1:0]              wptr,
  output ddl_pkg::scal_t             nxt,
  output logic [PW-1:0]              wptr_nxt,
  output logic [1:0]                 job
);
  import ddl_pkg::*;

  localparam int HALF = SAMPLE_SLOTS / 2;

  logic [SECS_W-1:0] sc_inc;

  assign sc_inc = cur.sec_count + 8'd1;

  // Work out the phase, interval, counters and buffer job for this tick
  always_comb begin
    nxt           = cur;
    nxt.sec_count = sc_inc;
    wptr_nxt      = wptr;
    job           = JOB_NONE;
    if (cur.phase == PH_IDLE) begin
      // the buffer is already all zero whenever the logger is idle
      if (dive_active && (dive_time_s >= {8'd0, start_delay_s})) begin
        nxt.sec_count = '0;
        nxt.interval  = INTERVAL_RST;
        nxt.phase     = PH_STARTED;
        wptr_nxt      = PW'(1);
      end
    end else if (dive_active) begin
      nxt.phase = PH_CONFIRMED;
      if (sc_inc >= cur.interval) begin
        nxt.sec_count = '0;
        if ((wptr >= PW'(SAMPLE_SLOTS)) && (cur.interval < INTERVAL_LIMIT)) begin
          nxt.interval = {cur.interval[INTERVAL_W-2:0], 1'b0};
          wptr_nxt     = PW'(HALF + 1);
          job          = JOB_COMPRESS;
        end else if (wptr < PW'(SAMPLE_SLOTS)) begin
          wptr_nxt = wptr + PW'(1);
          job      = JOB_STORE;
        end
      end
    end else if (cur.phase == PH_CONFIRMED) begin
      nxt.phase = PH_IDLE;
      job       = JOB_CLEAR;
    end
  end

endmodule

// ----- rtl/decimating_depth_logger.sv -----
// Top level: depth trace logger with decimating buffer in a two-read memory.
// Sequence: a read item goes through READ and EMIT, a tick without buffer work straight
// to EMIT, a stored sample through STORE, a compressing tick through PAIR, FILL and STORE,
// a clearing tick through CLEAR; the single write port of the trace memory serialises this work.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: synchronous, active low; then a clearing pass, no item taken.
`timescale 1ns / 1ps

module decimating_depth_logger #(
  parameter int SAMPLE_SLOTS = ddl_pkg::SAMPLE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: start_delay_s
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // dive_active, dive_time_s[15:0], depth_dm[15:0],
                                  // read_index[7:0], zero pad
  input  logic        in_tuser,   // op
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // read_value[15:0], sample_count[8:0],
                                  // tick_interval[7:0], recording, zero pad
);
  import ddl_pkg::*;

  localparam int AW   = $clog2(SAMPLE_SLOTS);
  localparam int PW   = $clog2(SAMPLE_SLOTS + 1);
  localparam int HALF = SAMPLE_SLOTS / 2;
  localparam int RW   = (AW > RIDX_W) ? AW : RIDX_W;
  localparam int EW   = (PW > COUNT_W) ? PW : COUNT_W;

  localparam logic [AW-1:0] LAST_IDX = AW'(SAMPLE_SLOTS - 1);
  localparam logic [AW-1:0] HALF_IDX = AW'(HALF);

  // Sequencer states
  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_PAIR  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_STORE = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  // Input field unpacking
  logic                in_dive;
  logic [DTIME_W-1:0]  in_dtime;
  logic [DEPTH_W-1:0]  in_depth;
  logic [RIDX_W-1:0]   in_ridx;
  logic [RW-1:0]       ridx_ext;

  assign in_dive  = in_tdata[0];
  assign in_dtime = in_tdata[16:1];
  assign in_depth = in_tdata[32:17];
  assign in_ridx  = in_tdata[40:33];
  assign ridx_ext = RW'(in_ridx);

  // Registers
  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pair_idx_r;
  scal_t               scal_r;
  logic [PW-1:0]       wptr_r;
  logic [7:0]          start_delay_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic [AW-1:0]       st_addr_r;
  logic                in_range_r;
  logic [DEPTH_W-1:0]  res_value_r, res_value_nxt;
  logic                out_valid_r;
  logic [39:0]         out_data_r;

  // Tick decision
  scal_t               scal_tk;
  logic [PW-1:0]       wptr_tk;
  logic [1:0]          job_tk;

  ddl_tick #(
    .SAMPLE_SLOTS (SAMPLE_SLOTS),
    .PW           (PW)
  ) u_tick (
    .dive_active   (in_dive),
    .dive_time_s   (in_dtime),
    .start_delay_s (start_delay_r),
    .cur           (scal_r),
    .wptr          (wptr_r),
    .nxt           (scal_tk),
    .wptr_nxt      (wptr_tk),
    .job           (job_tk)
  );

  logic accept;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Trace memory: two read ports, one write port
  logic [DEPTH_W-1:0] mem [SAMPLE_SLOTS];
  logic [AW-1:0]      rd_addr_a, rd_addr_b;
  logic [DEPTH_W-1:0] rd_a_r, rd_b_r;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [DEPTH_W-1:0] wr_data;
  logic [DEPTH_W:0]   pair_sum;

  // Pick read addresses: pairs while compressing, else the requested entry
  always_comb begin
    if (state_r == S_PAIR) begin
      rd_addr_a = {cnt_r[AW-2:0], 1'b0};
    end else begin
      rd_addr_a = ridx_ext[AW-1:0];
    end
    rd_addr_b = {cnt_r[AW-2:0], 1'b1};
  end

  assign pair_sum = {1'b0, rd_a_r} + {1'b0, rd_b_r};

  // Select the single write of this cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = '0;
    unique case (state_r)
      S_INIT, S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_PAIR: begin
        wr_en   = pend_r;
        wr_addr = pair_idx_r;
        wr_data = pair_sum[DEPTH_W:1];
      end
      S_FILL: begin
        wr_en   = 1'b1;
        wr_data = FILL_VALUE;
      end
      S_STORE: begin
        wr_en   = 1'b1;
        wr_addr = st_addr_r;
        wr_data = depth_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    res_value_nxt = res_value_r;
    unique case (state_r)
      S_INIT: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cnt_nxt       = '0;
          res_value_nxt = '0;
          if (in_tuser == OP_READ) begin
            state_nxt = S_READ;
          end else begin
            unique case (job_tk)
              JOB_STORE:    state_nxt = S_STORE;
              JOB_COMPRESS: state_nxt = S_PAIR;
              JOB_CLEAR:    state_nxt = S_CLEAR;
              default:      state_nxt = S_EMIT;
            endcase
          end
        end
      end
      S_CLEAR: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_PAIR: begin
        // issue pair reads for every index below the midpoint, drain one write after
        if (cnt_r == HALF_IDX) begin
          state_nxt = S_FILL;
        end else begin
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + AW'(1);
        end
      end
      S_FILL: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        state_nxt = S_EMIT;
      end
      S_READ: begin
        res_value_nxt = in_range_r ? rd_a_r : '0;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_INIT;
      cnt_r            <= '0;
      pend_r           <= 1'b0;
      scal_r.phase     <= PH_IDLE;
      scal_r.interval  <= INTERVAL_RST;
      scal_r.sec_count <= '0;
      wptr_r           <= '0;
      start_delay_r    <= START_DELAY_RST;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      if (cfg_we) begin
        start_delay_r <= cfg_wdata;
      end
      // advance the scalar state on an accepted tick
      if (accept && (in_tuser == OP_TICK)) begin
        scal_r <= scal_tk;
        wptr_r <= wptr_tk;
      end
      // hold the result until taken
      if ((state_r == S_EMIT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  logic [EW-1:0] wptr_ext;
  assign wptr_ext = EW'(wptr_r);

  always_ff @(posedge clk) begin
    res_value_r <= res_value_nxt;
    pair_idx_r  <= cnt_r;
    if (accept) begin
      depth_r    <= in_depth;
      in_range_r <= (int'(in_ridx) < SAMPLE_SLOTS);
      // a compressing tick writes its sample at the midpoint
      st_addr_r  <= (job_tk == JOB_COMPRESS) ? HALF_IDX : wptr_r[AW-1:0];
    end
    if ((state_r == S_EMIT) && (!out_valid_r || out_tready)) begin
      out_data_r <= {6'd0, (scal_r.phase != PH_IDLE), scal_r.interval,
                     wptr_ext[COUNT_W-1:0], res_value_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
